// ===== sv/e8ld_pkg.sv =====
package e8ld_pkg;

  localparam int Dimension  = 8;
  localparam int CoordWidth = 16;
  localparam int FracBits   = 8;
  localparam int PointWidth = 10;
  localparam int Cosets     = 2;

  // Half a unit in Q8.8, also the weight of one step of a doubled point.
  localparam int HalfUnit = (1 << FracBits) / 2;

  // Widths of the intermediate values.
  localparam int ShiftWidth = CoordWidth + 1;      // y - 1/2
  localparam int RoundWidth = PointWidth;          // rounded integer coordinate
  localparam int ErrWidth   = FracBits;            // |rounding error|, at most one half
  localparam int DiffWidth  = CoordWidth + 2;      // doubled point minus y
  localparam int SqWidth    = 2 * (CoordWidth + 1) - 1;
  localparam int DistWidth  = SqWidth + 3;
  localparam int IdxWidth   = $clog2(Dimension);

  localparam int InDataWidth  = Dimension * CoordWidth;
  localparam int OutDataWidth = ((Dimension * PointWidth + 7) / 8) * 8;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ShiftWidth-1:0] shift_t;
  typedef logic signed [RoundWidth-1:0] round_t;
  typedef logic        [ErrWidth-1:0]   err_t;
  typedef logic signed [PointWidth-1:0] point_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic        [SqWidth-1:0]    sq_t;
  typedef logic        [DistWidth-1:0]  dist_t;
  typedef logic        [IdxWidth-1:0]   idx_t;

endpackage

// ===== sv/e8_lattice_decoder.sv =====
// E8 nearest-point decoder, one vector of eight Q8.8 coordinates per item.
// The result passes through the round, parity fix, square, sum and compare
// registers in that order and is offered on out_* from the compare register.
// Throughput: one item per cycle while out_tready stays high; the five register stages (round, parity fix,
// square, sum, compare) each hold one item, and a stage advances when it is empty or the next one advances.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
module e8_lattice_decoder
  import e8ld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // coord_0 .. coord_7, 16 bits each, coord_0 in the lowest bits
  input  logic [InDataWidth-1:0]  in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // point_0 .. point_7, 10 bits each, point_0 in the lowest bits
  output logic [OutDataWidth-1:0] out_tdata,
  // coset_sel
  output logic                    out_tuser
);

  // Stage valid bits and advance enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5      = !v5_r || out_tready;
  assign adv4      = !v4_r || adv5;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Round both cosets half away from zero and keep the rounding errors.
  coord_t y_in [Dimension];
  round_t f_nxt  [Cosets][Dimension];
  err_t   e_nxt  [Cosets][Dimension];
  logic   up_nxt [Cosets][Dimension];

  coord_t y1_r  [Dimension];
  round_t f1_r  [Cosets][Dimension];
  err_t   e1_r  [Cosets][Dimension];
  logic   up1_r [Cosets][Dimension];

  always_comb begin : round_blk
    shift_t                  x;
    logic [ShiftWidth-1:0]   mag;
    logic [ShiftWidth-1:0]   rnd;
    round_t                  f;
    logic signed [DiffWidth:0] err;
    for (int i = 0; i < Dimension; i++) begin
      y_in[i] = coord_t'(in_tdata[i*CoordWidth +: CoordWidth]);
      for (int c = 0; c < Cosets; c++) begin
        if (c == 0) begin
          x = shift_t'(y_in[i]);
        end else begin
          x = shift_t'(y_in[i]) - shift_t'(HalfUnit);
        end
        mag = x[ShiftWidth-1] ? ShiftWidth'(-x) : ShiftWidth'(x);
        rnd = (mag + ShiftWidth'(HalfUnit)) >> FracBits;
        f   = x[ShiftWidth-1] ? -round_t'(rnd) : round_t'(rnd);
        // err is f in fixed point minus x; it is negative when x lies above f.
        err = ((DiffWidth+1)'(f) <<< FracBits) - (DiffWidth+1)'(x);
        f_nxt[c][i]  = f;
        up_nxt[c][i] = err[DiffWidth];
        e_nxt[c][i]  = err[DiffWidth] ? ErrWidth'(-err) : ErrWidth'(err);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      y1_r  <= y_in;
      f1_r  <= f_nxt;
      e1_r  <= e_nxt;
      up1_r <= up_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // An odd coordinate sum moves the worst-rounded coordinate one step
  // towards the input; the first index wins among equal errors.
  point_t p_nxt [Cosets][Dimension];
  coord_t y2_r [Dimension];
  point_t p2_r [Cosets][Dimension];

  always_comb begin : parity_blk
    idx_t   best;
    err_t   best_err;
    logic   odd;
    round_t pt;
    for (int c = 0; c < Cosets; c++) begin
      best     = '0;
      best_err = e1_r[c][0];
      odd      = 1'b0;
      for (int i = 0; i < Dimension; i++) begin
        odd = odd ^ f1_r[c][i][0];
        if (e1_r[c][i] > best_err) begin
          best_err = e1_r[c][i];
          best     = idx_t'(i);
        end
      end
      for (int i = 0; i < Dimension; i++) begin
        pt = f1_r[c][i];
        if (odd && (best == idx_t'(i))) begin
          pt = up1_r[c][i] ? pt + round_t'(1) : pt - round_t'(1);
        end
        p_nxt[c][i] = point_t'({pt, 1'b0}) | point_t'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      y2_r <= y1_r;
      p2_r <= p_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Squared per-coordinate distance, in units of 2^-16.
  sq_t    sq_nxt [Cosets][Dimension];
  point_t p3_r  [Cosets][Dimension];
  sq_t    sq3_r [Cosets][Dimension];

  always_comb begin : square_blk
    diff_t                        d;
    logic signed [2*DiffWidth-1:0] prod;
    for (int c = 0; c < Cosets; c++) begin
      for (int i = 0; i < Dimension; i++) begin
        d    = (diff_t'(p2_r[c][i]) <<< (FracBits - 1)) - diff_t'(y2_r[i]);
        prod = d * d;
        sq_nxt[c][i] = prod[SqWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      p3_r  <= p2_r;
      sq3_r <= sq_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 4
  dist_t  dist_nxt [Cosets];
  point_t p4_r    [Cosets][Dimension];
  dist_t  dist4_r [Cosets];

  always_comb begin
    for (int c = 0; c < Cosets; c++) begin
      dist_nxt[c] = ((dist_t'(sq3_r[c][0]) + dist_t'(sq3_r[c][1]))
                   + (dist_t'(sq3_r[c][2]) + dist_t'(sq3_r[c][3])))
                  + ((dist_t'(sq3_r[c][4]) + dist_t'(sq3_r[c][5]))
                   + (dist_t'(sq3_r[c][6]) + dist_t'(sq3_r[c][7])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      p4_r    <= p3_r;
      dist4_r <= dist_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Equal distances go to the half-integer coset.
  logic                    shifted_nxt;
  logic [OutDataWidth-1:0] data_nxt;
  logic [OutDataWidth-1:0] data5_r;
  logic                    coset5_r;

  always_comb begin
    shifted_nxt = !(dist4_r[0] < dist4_r[1]);
    data_nxt    = '0;
    for (int i = 0; i < Dimension; i++) begin
      data_nxt[i*PointWidth +: PointWidth] = shifted_nxt ? p4_r[1][i] : p4_r[0][i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv5 && v4_r) begin
      data5_r  <= data_nxt;
      coset5_r <= shifted_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = data5_r;
  assign out_tuser  = coset5_r;

  // ---------------------------------------------------------------- checks
  logic [1:0] pt_sum_lo;
  logic       lsb_or, lsb_and;

  always_comb begin
    pt_sum_lo = '0;
    lsb_or    = 1'b0;
    lsb_and   = 1'b1;
    for (int i = 0; i < Dimension; i++) begin
      pt_sum_lo = pt_sum_lo + data5_r[i*PointWidth +: 2];
      lsb_or    = lsb_or  | data5_r[i*PointWidth];
      lsb_and   = lsb_and & data5_r[i*PointWidth];
    end
  end

  // Every doubled coordinate is odd exactly when the shifted coset was chosen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser ? lsb_and : !lsb_or))
    else $error("point parity does not match coset_sel");

  // A lattice point of E8 has an even coordinate sum, so the doubled sum is 0 mod 4.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pt_sum_lo == 2'd0))
    else $error("decoded point is not in E8");

  // A full pipeline blocked at the output takes no new item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready) |-> !in_tready)
    else $error("input accepted while the pipeline is stalled");

  // Reset leaves nothing on the output.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

// ===== test/tb_e8_lattice_decoder.sv =====
module tb_e8_lattice_decoder;
  import e8ld_pkg::*;

  typedef int coord_list_t [Dimension];

  // Works out the nearest E8 point for every accepted vector and holds the
  // points still due from the decoder, oldest first.
  class e8_point_tracker;
    typedef longint vec_t [Dimension];
    typedef struct packed {
      logic                    coset;
      logic [OutDataWidth-1:0] points;
    } e8_point_t;

    e8_point_t awaited_points[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return awaited_points.size();
    endfunction

    // Nearest D8 point: round half away from zero, then repair odd parity on
    // the coordinate that rounded worst (first one on a tie).
    function automatic void d8_nearest(input vec_t x, output vec_t pt);
      vec_t   f;
      longint mag;
      longint err;
      longint worst_err;
      longint coord_sum;
      int     worst;
      worst_err = -1;
      worst = 0;
      coord_sum = 0;
      for (int i = 0; i < Dimension; i++) begin
        mag = (x[i] < 0) ? -x[i] : x[i];
        f[i] = (mag + HalfUnit) >>> FracBits;
        if (x[i] < 0) begin
          f[i] = -f[i];
        end
        coord_sum += f[i];
      end
      for (int i = 0; i < Dimension; i++) begin
        err = f[i] * (longint'(1) << FracBits) - x[i];
        if (err < 0) begin
          err = -err;
        end
        if (err > worst_err) begin
          worst_err = err;
          worst = i;
        end
      end
      pt = f;
      if (coord_sum[0]) begin
        if (x[worst] > f[worst] * (longint'(1) << FracBits)) begin
          pt[worst] = f[worst] + 1;
        end else begin
          pt[worst] = f[worst] - 1;
        end
      end
    endfunction

    function void note_vector(input logic [InDataWidth-1:0] data);
      vec_t      y;
      vec_t      y_shifted;
      vec_t      whole_pt;
      vec_t      half_pt;
      longint    whole_dist;
      longint    half_dist;
      longint    diff;
      longint    doubled;
      logic      pick_half;
      e8_point_t want;
      for (int i = 0; i < Dimension; i++) begin
        y[i] = longint'($signed(data[i*CoordWidth +: CoordWidth]));
        y_shifted[i] = y[i] - HalfUnit;
      end
      d8_nearest(y, whole_pt);
      d8_nearest(y_shifted, half_pt);
      whole_dist = 0;
      half_dist = 0;
      for (int i = 0; i < Dimension; i++) begin
        diff = 2 * whole_pt[i] * HalfUnit - y[i];
        whole_dist += diff * diff;
        diff = (2 * half_pt[i] + 1) * HalfUnit - y[i];
        half_dist += diff * diff;
      end
      // A tie in distance goes to the half-integer coset.
      pick_half = !(whole_dist < half_dist);
      want.coset = pick_half;
      for (int i = 0; i < Dimension; i++) begin
        doubled = pick_half ? 2 * half_pt[i] + 1 : 2 * whole_pt[i];
        want.points[i*PointWidth +: PointWidth] = doubled[PointWidth-1:0];
      end
      awaited_points.push_back(want);
    endfunction

    function void check_point(input logic [OutDataWidth-1:0] data, input logic coset);
      e8_point_t      want;
      logic [Dimension:0] bad;
      if (awaited_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: point %h coset %0d arrived with no vector pending", data, coset);
        end
        return;
      end
      want = awaited_points.pop_front();
      for (int k = 0; k < Dimension; k++) begin
        bad[k] = data[k*PointWidth +: PointWidth] !== want.points[k*PointWidth +: PointWidth];
      end
      bad[Dimension] = coset !== want.coset;
      if (bad != '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: fields %b (coset high) differ: expected points %h coset %0d, got %h coset %0d",
                   bad, want.points, want.coset, data, coset);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [InDataWidth-1:0]  in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OutDataWidth-1:0] out_tdata;
  logic                    out_tuser;

  int send_idle_pct = 34;
  int recv_idle_pct = 45;

  e8_point_tracker tracker = new();

  e8_lattice_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_point(out_tdata, out_tuser);
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [InDataWidth-1:0] pack_coords(input coord_list_t c);
    logic [InDataWidth-1:0] data;
    for (int i = 0; i < Dimension; i++) begin
      data[i*CoordWidth +: CoordWidth] = c[i][CoordWidth-1:0];
    end
    return data;
  endfunction

  // Mostly vectors close to points of either coset, so that both candidates
  // and the parity repair are exercised, with raw and extreme vectors mixed in.
  function automatic logic [InDataWidth-1:0] random_vector();
    coord_list_t c;
    int          shape;
    shape = $urandom_range(9);
    for (int i = 0; i < Dimension; i++) begin
      case (shape)
        0, 1, 2: begin
          c[i] = int'($signed($urandom_range(65535) - 32768));
        end
        3, 4, 5, 6: begin
          c[i] = (int'($urandom_range(254)) - 127) * 256 + (shape[0] ? HalfUnit : 0)
                 + int'($urandom_range(255)) - 128;
        end
        7, 8: begin
          c[i] = int'($urandom_range(1023)) - 512;
        end
        default: begin
          case ($urandom_range(3))
            0: c[i] = 32767;
            1: c[i] = -32768;
            2: c[i] = (int'($urandom_range(1)) * 2 - 1) * HalfUnit;
            default: c[i] = int'($urandom_range(65535)) - 32768;
          endcase
        end
      endcase
    end
    return pack_coords(c);
  endfunction

  task automatic send_item(input logic [InDataWidth-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    tracker.note_vector(data);
  endtask

  initial begin
    coord_list_t walk;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(pack_coords('{default: 0}));
    send_item(pack_coords('{default: 32767}));
    send_item(pack_coords('{default: -32768}));
    send_item(pack_coords('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768}));
    // Exact integer vectors with an odd sum: every error is zero.
    send_item(pack_coords('{256, 0, 0, 0, 0, 0, 0, 0}));
    send_item(pack_coords('{0, 0, 0, 0, 0, 0, 0, -256}));
    send_item(pack_coords('{256, 256, 256, 0, 0, 0, 0, 0}));
    // A quarter everywhere is equally far from both cosets.
    send_item(pack_coords('{default: 64}));
    send_item(pack_coords('{default: -64}));
    send_item(pack_coords('{default: 128}));
    send_item(pack_coords('{default: -128}));
    send_item(pack_coords('{default: 127}));
    send_item(pack_coords('{default: -129}));
    send_item(pack_coords('{128, -128, 384, -384, 640, -640, 896, -896}));
    send_item(pack_coords('{100, -100, 100, -100, 0, 0, 0, 156}));
    for (int k = 0; k < Dimension; k++) begin
      walk = '{default: 32767};
      walk[k] = -32768;
      send_item(pack_coords(walk));
    end

    for (int n = 0; n < 550; n++) begin
      send_item(random_vector());
      if (n == 200) begin
        // Let the pipeline run dry before carrying on.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
      end
    end

    send_idle_pct = 45;
    recv_idle_pct = 34;
    for (int n = 0; n < 550; n++) begin
      send_item(random_vector());
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 550; n++) begin
      send_item(random_vector());
    end

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
